[rtl/core/cct_pkg.sv]
// Types, constants and the month length table for the calendar clock.
package cct_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DATE_W  = 5;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MS_W    = 10;

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [YEAR_W-1:0]  YEAR_LAST  = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
	localparam logic [WDAY_W-1:0]  WDAY_LAST  = WDAY_W'(6);
	localparam logic [HOUR_W-1:0]  HOUR_LAST  = HOUR_W'(23);
	localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(59);
	localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(59);
	localparam logic [1:0]         LEAP_MASK  = 2'h3;

	localparam logic [DATE_W-1:0] LEN_28 = DATE_W'(28);
	localparam logic [DATE_W-1:0] LEN_29 = DATE_W'(29);
	localparam logic [DATE_W-1:0] LEN_30 = DATE_W'(30);
	localparam logic [DATE_W-1:0] LEN_31 = DATE_W'(31);

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_LOAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic [MS_W-1:0]   milli;
		logic [SEC_W-1:0]  second;
		logic [MIN_W-1:0]  minute;
		logic [HOUR_W-1:0] hour;
		logic [WDAY_W-1:0] weekday;
		logic [DATE_W-1:0] date;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0] year;
	} time_t;

	typedef struct packed {
		logic [MIN_W-1:0]   new_minute;
		logic [HOUR_W-1:0]  new_hour;
		logic [WDAY_W-1:0]  new_weekday;
		logic [DATE_W-1:0]  new_date;
		logic [MONTH_W-1:0] new_month;
		logic [YEAR_W-1:0]  new_year;
		logic [MS_W-1:0]    elapsed_ms;
		kind_t              kind;
	} item_t;

	localparam time_t TIME_RESET = '{
		milli:   '0,
		second:  '0,
		minute:  '0,
		hour:    '0,
		weekday: WDAY_W'(2),
		date:    DATE_W'(4),
		month:   MONTH_W'(10),
		year:    YEAR_W'(2011)
	};

	function automatic logic [DATE_W-1:0] month_len(
		input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0]  year
	);
		logic [DATE_W-1:0] len;
		case (month) inside
			MONTH_FEB: len = ((year[1:0] & LEAP_MASK) == 2'b00) ? LEN_29 : LEN_28;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_31;
			default: len = LEN_30;
		endcase
		return len;
	endfunction

endpackage

[rtl/core/cct_step.sv]
// Next time of day and date from the current time and one tick or load.
module cct_step #(
	parameter int unsigned TICKS_PER_SECOND = 1000
) (
	input  cct_pkg::time_t cur,
	input  cct_pkg::item_t item,
	output cct_pkg::time_t nxt
);

	localparam int unsigned SUM_W = cct_pkg::MS_W + 1;
	localparam logic [cct_pkg::MS_W-1:0] TPS = cct_pkg::MS_W'(TICKS_PER_SECOND);
	localparam logic [SUM_W-1:0] TPS_SUM = SUM_W'(TICKS_PER_SECOND);

	logic [cct_pkg::MS_W-1:0]   ms_clamped;
	logic [SUM_W-1:0]           ms_sum;
	logic [SUM_W-1:0]           ms_wrapped;
	logic                       sec_carry;
	logic                       sec_wrap;
	logic                       min_wrap;
	logic                       hour_wrap;
	logic                       day_carry;
	logic                       month_end;
	cct_pkg::time_t             ticked;

	always_comb begin
		ms_clamped = (item.elapsed_ms > TPS) ? TPS : item.elapsed_ms;
		ms_sum     = {1'b0, cur.milli} + {1'b0, ms_clamped};
		sec_carry  = (ms_sum >= TPS_SUM);
		ms_wrapped = sec_carry ? (ms_sum - TPS_SUM) : ms_sum;

		sec_wrap  = (cur.second >= cct_pkg::SEC_LAST);
		min_wrap  = (cur.minute >= cct_pkg::MIN_LAST);
		hour_wrap = (cur.hour >= cct_pkg::HOUR_LAST);
		day_carry = sec_carry && sec_wrap && min_wrap && hour_wrap;
		month_end = (cur.date >= cct_pkg::month_len(cur.month, cur.year));

		ticked       = cur;
		ticked.milli = ms_wrapped[cct_pkg::MS_W-1:0];
		if (sec_carry) begin
			ticked.second = sec_wrap ? '0 : cur.second + 1'b1;
			if (sec_wrap) begin
				ticked.minute = min_wrap ? '0 : cur.minute + 1'b1;
				if (min_wrap) begin
					ticked.hour = hour_wrap ? '0 : cur.hour + 1'b1;
				end
			end
		end
		if (day_carry) begin
			ticked.weekday = (cur.weekday >= cct_pkg::WDAY_LAST) ? '0 : cur.weekday + 1'b1;
			if (month_end) begin
				ticked.date = cct_pkg::DATE_W'(1);
				if (cur.month >= cct_pkg::MONTH_LAST) begin
					ticked.month = cct_pkg::MONTH_W'(1);
					ticked.year  = (cur.year >= cct_pkg::YEAR_LAST) ? '0 : cur.year + 1'b1;
				end else begin
					ticked.month = cur.month + 1'b1;
				end
			end else begin
				ticked.date = cur.date + 1'b1;
			end
		end

		case (item.kind)
			cct_pkg::KIND_LOAD: begin
				nxt         = cur;
				nxt.year    = item.new_year;
				nxt.month   = item.new_month;
				nxt.date    = item.new_date;
				nxt.weekday = item.new_weekday;
				nxt.hour    = item.new_hour;
				nxt.minute  = item.new_minute;
				nxt.second  = '0;
			end
			default: begin
				nxt = ticked;
			end
		endcase
	end

endmodule

[rtl/core/calendar_clock_tick.sv]
// Top level of the calendar clock: input register, time register and handshakes.
//
//  channel | dir | tdata fields (low bit first)                        | tuser
//  s_      | in  | elapsed_ms, new_year, new_month, new_date,          | kind
//          |     | new_weekday, new_hour, new_minute                    |
//  m_      | out | year, month, date, weekday, hour, minute, second,   | -
//          |     | millisecond                                          |
//
// One item per cycle sustained unless stalled. The time register doubles as
// the output register, so it advances only when the previous result has been
// taken. The input register takes a new item while a result waits only if it
// is empty. Reset loads the time to 4 October 2011, a Tuesday, midnight.
module calendar_clock_tick #(
	parameter int unsigned TICKS_PER_SECOND = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// elapsed_ms, new_year, new_month, new_date, new_weekday, new_hour, new_minute
	input  logic [cct_pkg::IN_DATA_W-1:0]       s_tdata,
	// kind
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// year, month, date, weekday, hour, minute, second, millisecond
	output logic [cct_pkg::OUT_DATA_W-1:0]      m_tdata
);

	cct_pkg::item_t item_s1;
	logic           valid_s1;
	cct_pkg::time_t time_q;
	cct_pkg::time_t time_nxt;
	logic           out_valid_q;
	logic           advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{
				kind:        cct_pkg::kind_t'(s_tuser),
				elapsed_ms:  s_tdata[9:0],
				new_year:    s_tdata[23:10],
				new_month:   s_tdata[27:24],
				new_date:    s_tdata[32:28],
				new_weekday: s_tdata[35:33],
				new_hour:    s_tdata[40:36],
				new_minute:  s_tdata[46:41]
			};
		end
	end

	cct_step #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_step (
		.cur  (time_q),
		.item (item_s1),
		.nxt  (time_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= cct_pkg::TIME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				time_q <= time_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, time_q.milli, time_q.second, time_q.minute, time_q.hour,
		time_q.weekday, time_q.date, time_q.month, time_q.year};

`ifndef SYNTHESIS
	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_milli_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (time_q.milli < cct_pkg::MS_W'(TICKS_PER_SECOND)))
		else $error("millisecond count out of range");

	a_load_clears_second: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == cct_pkg::KIND_LOAD) |=> (time_q.second == '0))
		else $error("load did not clear the second");
`endif

endmodule
